>>> rtl/core/epoch_seconds_to_calendar_date_top_macros.svh
// assertion helpers for the epoch seconds to calendar date block
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ES2CD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ES2CD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/es2cd_pkg.sv
package es2cd_pkg;

    // port widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 1;

    // pipeline depth, input register through output register
    localparam int STAGES = 7;

    // seconds per day and the first second of 2070
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [31:0] RANGE_LIMIT  = 32'd3155760000;

    // reciprocals for constant division: q = (x * recip) >> shift
    // days = (t >> 7) / 675
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    // x / 15, used for seconds to minutes and minutes to hours after >> 2
    localparam logic [15:0] RECIP_15   = 16'd34953;
    // x / 7 for the weekday
    localparam logic [17:0] RECIP_7    = 18'd149797;
    // days / 1461 for the four-year cycle
    localparam logic [16:0] RECIP_QUAD = 17'd91868;

    localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;
    localparam logic [7:0]  BASE_YEAR     = 8'd70;

    // month index codes
    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_MAR = 4'd2;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_JUL = 4'd6;
    localparam logic [3:0] MON_AUG = 4'd7;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    // zero-based day of year on which a month starts
    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        logic [8:0] adj;
        case (mon)
            MON_JAN: base = 9'd0;
            MON_FEB: base = 9'd31;
            MON_MAR: base = 9'd59;
            MON_APR: base = 9'd90;
            MON_MAY: base = 9'd120;
            MON_JUN: base = 9'd151;
            MON_JUL: base = 9'd181;
            MON_AUG: base = 9'd212;
            MON_SEP: base = 9'd243;
            MON_OCT: base = 9'd273;
            MON_NOV: base = 9'd304;
            MON_DEC: base = 9'd334;
            default: base = 9'd0;
        endcase
        adj = (leap && (mon >= MON_MAR)) ? 9'd1 : 9'd0;
        return base + adj;
    endfunction

endpackage

>>> rtl/core/epoch_seconds_to_calendar_date_top.sv
// channel   | dir | handshake                          | payload
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata: epoch_seconds
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tdata: date and time, tuser: range flag
//
// one transaction accepted per cycle when the output side keeps up
// seven register stages from input to output, the
// depth set by the reciprocal multipliers for /86400, /60, /7 and /1461
// i_rst_n is synchronous, active low, and clears the stage valid bits only
// a stalled output holds its stage; upstream stages keep filling any gaps, and
// o_s_axis_tready falls only when every stage holds a waiting transaction
`include "epoch_seconds_to_calendar_date_top_macros.svh"

module epoch_seconds_to_calendar_date_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] epoch_seconds
    input  logic [es2cd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] year_since_1900, [36:28] day_of_year, [40:37] month,
    // [45:41] day_of_month, [47:46] zero
    output logic [es2cd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] range_error
    output logic [es2cd_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);
    import es2cd_pkg::*;

    // stage control
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] stage_en;

    // stage 0: input register
    logic [31:0] r_s0_t;

    // stage 1: day count estimate
    logic [31:0] r_s1_t;
    logic [15:0] r_s1_q;
    logic        r_s1_rng;
    logic [50:0] prod_day;
    logic [15:0] n_s1_q;
    logic        n_s1_rng;

    // stage 2: seconds of day
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_sod;
    logic        r_s2_rng;
    logic [32:0] prod_sod;
    logic [31:0] diff_sod;
    logic [16:0] n_s2_sod;

    // stage 3: minute of day, weekday and cycle quotients
    logic [16:0] r_s3_sod;
    logic [15:0] r_s3_days;
    logic [10:0] r_s3_mod;
    logic [13:0] r_s3_q7;
    logic [5:0]  r_s3_quads;
    logic        r_s3_rng;
    logic [30:0] prod_mod;
    logic [16:0] x7;
    logic [34:0] prod_w;
    logic [32:0] prod_quad;
    logic [10:0] n_s3_mod;
    logic [13:0] n_s3_q7;
    logic [5:0]  n_s3_quads;

    // stage 4: second, hour, weekday and day within the cycle
    logic [5:0]  r_s4_sec;
    logic [4:0]  r_s4_hour;
    logic [10:0] r_s4_mod;
    logic [2:0]  r_s4_wday;
    logic [5:0]  r_s4_quads;
    logic [10:0] r_s4_rem;
    logic        r_s4_rng;
    logic [16:0] mod60;
    logic [16:0] diff_sec;
    logic [24:0] prod_hr;
    logic [16:0] q7x7;
    logic [16:0] diff_wd;
    logic [15:0] quad_days;
    logic [15:0] diff_rem;
    logic [5:0]  n_s4_sec;
    logic [4:0]  n_s4_hour;
    logic [2:0]  n_s4_wday;
    logic [10:0] n_s4_rem;

    // stage 5: minute, year and day of year
    logic [5:0]  r_s5_sec;
    logic [5:0]  r_s5_min;
    logic [4:0]  r_s5_hour;
    logic [2:0]  r_s5_wday;
    logic [7:0]  r_s5_year;
    logic [8:0]  r_s5_yday;
    logic        r_s5_leap;
    logic        r_s5_rng;
    logic [10:0] hour60;
    logic [10:0] diff_min;
    logic [1:0]  yr_off;
    logic [10:0] yday_wide;
    logic [5:0]  n_s5_min;
    logic [7:0]  n_s5_year;
    logic [8:0]  n_s5_yday;

    // stage 6: output register with month and day of month
    logic [5:0]  r_out_sec;
    logic [5:0]  r_out_min;
    logic [4:0]  r_out_hour;
    logic [2:0]  r_out_wday;
    logic [7:0]  r_out_year;
    logic [8:0]  r_out_yday;
    logic [3:0]  r_out_mon;
    logic [4:0]  r_out_mday;
    logic        r_out_rng;
    logic [3:0]  n_out_mon;
    logic [8:0]  mday_wide;
    logic [4:0]  n_out_mday;

    // terms for the checks
    logic        out_fields_ok;
    logic        out_rng_ok;
    logic        out_first_day;
    logic        out_jan_first;
    logic        pipe_blocked;
    logic        in_accept;

    // stage enables: a stage moves when it is empty or its successor moves
    always_comb begin
        stage_en[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign n_vld = {r_vld[STAGES-2:0], i_s_axis_tvalid};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 1 logic: days = (t >> 7) / 675 by reciprocal
    always_comb begin
        prod_day = {26'b0, r_s0_t[31:7]} * {25'b0, RECIP_675};
        n_s1_q   = prod_day[50:35];
        n_s1_rng = (r_s0_t >= RANGE_LIMIT);
    end

    // stage 2 logic: remainder within the day
    always_comb begin
        prod_sod = {17'b0, r_s1_q} * {16'b0, SECS_PER_DAY};
        diff_sod = r_s1_t - prod_sod[31:0];
        n_s2_sod = diff_sod[16:0];
    end

    // stage 3 logic: minute of day, weekday quotient, four-year cycles
    always_comb begin
        prod_mod   = {16'b0, r_s2_sod[16:2]} * {15'b0, RECIP_15};
        n_s3_mod   = prod_mod[29:19];
        x7         = {1'b0, r_s2_days} + 17'd4;
        prod_w     = {18'b0, x7} * {17'b0, RECIP_7};
        n_s3_q7    = prod_w[33:20];
        prod_quad  = {17'b0, r_s2_days} * {16'b0, RECIP_QUAD};
        n_s3_quads = prod_quad[32:27];
    end

    // stage 4 logic: second, hour, weekday and day within the cycle
    always_comb begin
        mod60     = {6'b0, r_s3_mod} * 17'd60;
        diff_sec  = r_s3_sod - mod60;
        n_s4_sec  = diff_sec[5:0];
        prod_hr   = {16'b0, r_s3_mod[10:2]} * {9'b0, RECIP_15};
        n_s4_hour = prod_hr[23:19];
        q7x7      = {3'b0, r_s3_q7} * 17'd7;
        diff_wd   = {1'b0, r_s3_days} + 17'd4 - q7x7;
        n_s4_wday = diff_wd[2:0];
        quad_days = {10'b0, r_s3_quads} * DAYS_PER_QUAD;
        diff_rem  = r_s3_days - quad_days;
        n_s4_rem  = diff_rem[10:0];
    end

    // stage 5 logic: minute, then year within the cycle, the third year being leap
    always_comb begin
        hour60   = {6'b0, r_s4_hour} * 11'd60;
        diff_min = r_s4_mod - hour60;
        n_s5_min = diff_min[5:0];
        if (r_s4_rem < 11'd365) begin
            yr_off    = 2'd0;
            yday_wide = r_s4_rem;
        end else if (r_s4_rem < 11'd730) begin
            yr_off    = 2'd1;
            yday_wide = r_s4_rem - 11'd365;
        end else if (r_s4_rem < 11'd1096) begin
            yr_off    = 2'd2;
            yday_wide = r_s4_rem - 11'd730;
        end else begin
            yr_off    = 2'd3;
            yday_wide = r_s4_rem - 11'd1096;
        end
        n_s5_yday = yday_wide[8:0];
        n_s5_year = BASE_YEAR + {r_s4_quads, 2'b00} + {6'b0, yr_off};
    end

    // output stage logic: month search over the start table
    always_comb begin
        n_out_mon = MON_JAN;
        for (int m = 1; m < 12; m++) begin
            if (r_s5_yday >= month_start(4'(m), r_s5_leap)) begin
                n_out_mon = 4'(m);
            end
        end
        mday_wide  = r_s5_yday - month_start(n_out_mon, r_s5_leap) + 9'd1;
        n_out_mday = mday_wide[4:0];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s0_t <= i_s_axis_tdata[31:0];
        end
        if (stage_en[1]) begin
            r_s1_t   <= r_s0_t;
            r_s1_q   <= n_s1_q;
            r_s1_rng <= n_s1_rng;
        end
        if (stage_en[2]) begin
            r_s2_days <= r_s1_q;
            r_s2_sod  <= n_s2_sod;
            r_s2_rng  <= r_s1_rng;
        end
        if (stage_en[3]) begin
            r_s3_sod   <= r_s2_sod;
            r_s3_days  <= r_s2_days;
            r_s3_mod   <= n_s3_mod;
            r_s3_q7    <= n_s3_q7;
            r_s3_quads <= n_s3_quads;
            r_s3_rng   <= r_s2_rng;
        end
        if (stage_en[4]) begin
            r_s4_sec   <= n_s4_sec;
            r_s4_hour  <= n_s4_hour;
            r_s4_mod   <= r_s3_mod;
            r_s4_wday  <= n_s4_wday;
            r_s4_quads <= r_s3_quads;
            r_s4_rem   <= n_s4_rem;
            r_s4_rng   <= r_s3_rng;
        end
        if (stage_en[5]) begin
            r_s5_sec  <= r_s4_sec;
            r_s5_min  <= n_s5_min;
            r_s5_hour <= r_s4_hour;
            r_s5_wday <= r_s4_wday;
            r_s5_year <= n_s5_year;
            r_s5_yday <= n_s5_yday;
            r_s5_leap <= (yr_off == 2'd2);
            r_s5_rng  <= r_s4_rng;
        end
        if (stage_en[6]) begin
            r_out_sec  <= r_s5_sec;
            r_out_min  <= r_s5_min;
            r_out_hour <= r_s5_hour;
            r_out_wday <= r_s5_wday;
            r_out_year <= r_s5_year;
            r_out_yday <= r_s5_yday;
            r_out_mon  <= n_out_mon;
            r_out_mday <= n_out_mday;
            r_out_rng  <= r_s5_rng;
        end
    end

    // ports
    assign o_s_axis_tready = stage_en[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = {2'b00, r_out_mday, r_out_mon, r_out_yday, r_out_year,
                              r_out_wday, r_out_hour, r_out_min, r_out_sec};
    assign o_m_axis_tuser  = r_out_rng;

    // check terms
    assign out_fields_ok = (r_out_sec < 6'd60) && (r_out_min < 6'd60) && (r_out_hour < 5'd24) &&
                           (r_out_wday < 3'd7) && (r_out_mon <= MON_DEC) && (r_out_mday != 5'd0);
    assign out_rng_ok    = (r_out_rng == (r_out_year >= 8'd170));
    assign out_first_day = o_m_axis_tvalid && (r_out_yday == 9'd0);
    assign out_jan_first = (r_out_mon == MON_JAN) && (r_out_mday == 5'd1);
    assign pipe_blocked  = o_m_axis_tvalid && !i_m_axis_tready && (r_vld == {STAGES{1'b1}});
    assign in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    // checks
    `ES2CD_ASSERT_IMP(a_fields_in_range, o_m_axis_tvalid, out_fields_ok, "field out of range")
    `ES2CD_ASSERT_IMP(a_range_flag_year, o_m_axis_tvalid, out_rng_ok, "range flag wrong for year")
    `ES2CD_ASSERT_IMP(a_new_year_day, out_first_day, out_jan_first, "first day not 1 January")
    `ES2CD_ASSERT_IMP(a_stall_only_when_full, !o_s_axis_tready, pipe_blocked, "stall with room")
    `ES2CD_ASSERT_NXT(a_accept_fills_stage, in_accept, r_vld[0], "transaction not captured")

endmodule

>>> tb/sv/epoch_seconds_to_calendar_date_top_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date_top_tb;

    import es2cd_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int HOLD_CYCLES   = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int SECS_IN_DAY   = 86400;
    localparam int DAYS_IN_QUAD  = 1461;
    localparam int LAST_DAY      = 49710;

    // broken-down date, laid out as in tdata with the lowest field last
    typedef struct packed {
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [8:0] day_of_year;
        logic [7:0] year_since_1900;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_cal_date;

    typedef struct {
        logic [31:0] secs;
        t_cal_date   date;
        logic        past_2069;
    } t_date_expect;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [31:0] epoch_seconds
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] year_since_1900, [36:28] day_of_year, [40:37] month,
    // [45:41] day_of_month, [47:46] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // [0] range_error
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    logic [31:0]  pending_secs[$];
    t_date_expect expected_dates[$];
    int           idle_pct = 0;
    int           stall_pct = 0;
    logic         hold_req = 1'b0;
    int           hold_cnt = 0;
    int           quiet_cycles = 0;
    int           errors = 0;

    epoch_seconds_to_calendar_date_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // date arithmetic with every year divisible by four taken as leap
    function automatic t_cal_date epoch_to_date(input logic [31:0] secs);
        int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned t;
        int unsigned days;
        int unsigned quads;
        int unsigned yr;
        int unsigned rem;
        int unsigned mon;
        int unsigned mlen;
        t_cal_date   d;
        t     = secs;
        days  = t / SECS_IN_DAY;
        quads = days / DAYS_IN_QUAD;
        yr    = 70 + quads * 4;
        rem   = days - quads * DAYS_IN_QUAD;
        if (rem > 364) begin
            yr++;
            rem -= 365;
        end
        if (rem > 364) begin
            yr++;
            rem -= 365;
        end
        if (rem > 365) begin
            yr++;
            rem -= 366;
        end
        d.day_of_year = rem[8:0];
        // walk the month table, february one day longer in leap years
        mon  = 0;
        mlen = month_len[0];
        while (mon < 11 && rem >= mlen) begin
            rem -= mlen;
            mon++;
            mlen = month_len[mon] + ((mon == 1 && yr % 4 == 0) ? 1 : 0);
        end
        d.second          = 6'(t % 60);
        d.minute          = 6'((t / 60) % 60);
        d.hour            = 5'((t / 3600) % 24);
        d.weekday         = 3'((days + 4) % 7);
        d.year_since_1900 = yr[7:0];
        d.month           = mon[3:0];
        d.day_of_month    = 5'(rem + 1);
        return d;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, input logic [31:0] secs);
        if (want != got) begin
            errors++;
            $display("%0t: mismatch %s for epoch %0d: expected %0d, actual %0d",
                     $time, name, secs, want, got);
        end
    endtask

    // sender: offers the next pending transaction once the current one is taken
    always @(posedge i_clk) begin
        t_date_expect e;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                e.secs      = i_s_axis_tdata;
                e.date      = epoch_to_date(i_s_axis_tdata);
                e.past_2069 = (i_s_axis_tdata >= RANGE_LIMIT);
                expected_dates.push_back(e);
            end
            if (pending_secs.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= pending_secs.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request, result checking
    always @(posedge i_clk) begin
        t_date_expect e;
        t_cal_date    got;
        if (o_m_axis_tvalid && i_m_axis_tready && i_rst_n) begin
            got = t_cal_date'(o_m_axis_tdata[$bits(t_cal_date)-1:0]);
            if (expected_dates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                e = expected_dates.pop_front();
                check_field("second", 32'(e.date.second), 32'(got.second), e.secs);
                check_field("minute", 32'(e.date.minute), 32'(got.minute), e.secs);
                check_field("hour", 32'(e.date.hour), 32'(got.hour), e.secs);
                check_field("weekday", 32'(e.date.weekday), 32'(got.weekday), e.secs);
                check_field("year_since_1900", 32'(e.date.year_since_1900),
                            32'(got.year_since_1900), e.secs);
                check_field("day_of_year", 32'(e.date.day_of_year),
                            32'(got.day_of_year), e.secs);
                check_field("month", 32'(e.date.month), 32'(got.month), e.secs);
                check_field("day_of_month", 32'(e.date.day_of_month),
                            32'(got.day_of_month), e.secs);
                check_field("range_error", 32'(e.past_2069), 32'(o_m_axis_tuser[0]), e.secs);
            end
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            i_m_axis_tready <= 1'b0;
            hold_cnt        <= hold_cnt + 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sender pauses until every outstanding result has come back
    task automatic drain_pipeline();
        while (pending_secs.size() != 0 || i_s_axis_tvalid || expected_dates.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_random_batch(input int count, input int idle, input int stall);
        logic [63:0] wide;
        int unsigned day;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3, 0))
                // anywhere in the 32-bit range
                0: wide = 64'($urandom());
                // just either side of midnight
                1: begin
                    day  = $urandom_range(LAST_DAY, 0);
                    wide = 64'(day) * 64'(SECS_IN_DAY);
                    if ($urandom_range(1, 0))
                        wide += 64'($urandom_range(2, 0));
                    else
                        wide += 64'(SECS_IN_DAY - 1) - 64'($urandom_range(2, 0));
                end
                // any day of any four-year cycle
                2: begin
                    day  = $urandom_range(33, 0) * DAYS_IN_QUAD + $urandom_range(1460, 0);
                    wide = 64'(day) * 64'(SECS_IN_DAY) +
                           64'($urandom_range(SECS_IN_DAY - 1, 0));
                end
                // around the start of 2070
                default: wide = 64'(RANGE_LIMIT) - 64'd200000 +
                                64'($urandom_range(400000, 0));
            endcase
            pending_secs.push_back(wide[31:0]);
        end
        drain_pipeline();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, year and month edges, leap days, 2070 boundary
        pending_secs.push_back(32'd0);
        pending_secs.push_back(32'd59);
        pending_secs.push_back(32'd60);
        pending_secs.push_back(32'd3599);
        pending_secs.push_back(32'd3600);
        pending_secs.push_back(32'd86399);
        pending_secs.push_back(32'd86400);
        pending_secs.push_back(32'(64'd364 * SECS_IN_DAY + 86399));
        pending_secs.push_back(32'(64'd365 * SECS_IN_DAY));
        pending_secs.push_back(32'(64'd788 * SECS_IN_DAY + 86399));
        pending_secs.push_back(32'(64'd789 * SECS_IN_DAY));
        pending_secs.push_back(32'(64'd790 * SECS_IN_DAY));
        pending_secs.push_back(32'(64'd1095 * SECS_IN_DAY));
        pending_secs.push_back(32'(64'd1096 * SECS_IN_DAY));
        pending_secs.push_back(32'(64'd1460 * SECS_IN_DAY + 86399));
        pending_secs.push_back(32'(64'd1461 * SECS_IN_DAY));
        pending_secs.push_back(32'h7FFF_FFFF);
        pending_secs.push_back(32'h8000_0000);
        pending_secs.push_back(RANGE_LIMIT - 32'd1);
        pending_secs.push_back(RANGE_LIMIT);
        // leap day of 2100, kept by the simplified rule
        pending_secs.push_back(32'(64'd47541 * SECS_IN_DAY));
        pending_secs.push_back(32'hAAAA_AAAA);
        pending_secs.push_back(32'h5555_5555);
        pending_secs.push_back(32'hFFFF_FFFF);
        drain_pipeline();

        send_random_batch(120, 0, 0);
        send_random_batch(120, 53, 0);
        send_random_batch(120, 0, 53);
        send_random_batch(100, 22, 22);

        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        send_random_batch(40, 0, 0);
        hold_req = 1'b0;

        repeat (4 * STAGES) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> epoch_seconds_to_calendar_date_top.f
+incdir+rtl/core
rtl/core/es2cd_pkg.sv
rtl/core/epoch_seconds_to_calendar_date_top.sv
tb/sv/epoch_seconds_to_calendar_date_top_tb.sv
